// File: src/assert_macros.svh
// Assertion helpers used by the checker file dds_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge out of reset.
`define DDS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that, once seen, implies another on the next edge.
`define DDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dds_pkg.sv
// -----------------------------------------------------------------------------
// dds_pkg
// Types, codes and constants of the decimal delta stream decoder.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dds_pkg;

    localparam int STATS_HEADER_BYTES_DEF = 48;
    localparam int ADDR_W                 = 4;
    localparam int JOB_QUEUE_DEPTH        = 4;
    localparam int RES_QUEUE_DEPTH        = 2;

    localparam logic REG_VALUE_COUNT   = 1'b0;
    localparam logic REG_SOURCE_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        ST_VALUE = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_EXP,
        PH_WIDTH,
        PH_BASE,
        PH_DELTA,
        PH_DRAIN
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } item_t;

    typedef struct packed {
        logic [63:0] value_bits;
        status_t     status;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic        is_value;
        status_t     status;
        logic        last;
        logic [2:0]  ex;
        logic [63:0] sum;
    } job_t;

    typedef struct packed {
        logic       is_value;
        status_t    status;
        logic       last;
        logic       sign;
        logic [2:0] ex;
    } meta_t;

    // Double bit patterns of 1 / 10^e.
    function automatic logic [63:0] recip_bits(input logic [2:0] e);
        logic [63:0] r;
        case (e)
            3'd0:    r = 64'h3FF0000000000000;
            3'd1:    r = 64'h3FB999999999999A;
            3'd2:    r = 64'h3F847AE147AE147B;
            3'd3:    r = 64'h3F50624DD2F1A9FC;
            3'd4:    r = 64'h3F1A36E2EB1C432D;
            3'd5:    r = 64'h3EE4F8B588E368F1;
            3'd6:    r = 64'h3EB0C6F7A0B5ED8D;
            3'd7:    r = 64'h3E7AD7F29ABCAF48;
            default: r = 64'h3FF0000000000000;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] lzc8(input logic [7:0] v);
        logic [3:0] n;
        logic       hit;
        n   = 4'd0;
        hit = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!hit && !v[i]) begin
                n = n + 4'd1;
            end else begin
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// File: src/dds_fifo.sv
// -----------------------------------------------------------------------------
// dds_fifo
// Small flop-based first-in first-out queue of words.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dds_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: src/dds_parser.sv
// -----------------------------------------------------------------------------
// dds_parser
// Front end: walks the frame byte by byte, checks the header, assembles the
// base and zigzag deltas, and issues one job per result.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dds_parser import dds_pkg::*; #(
    parameter int STATS_HEADER_BYTES = STATS_HEADER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    input  logic        accept,
    input  logic [31:0] value_count,
    input  logic [33:0] source_length,
    output job_t        job,
    output logic        job_push
);

    localparam int POS_W = $clog2(STATS_HEADER_BYTES + 9);
    localparam logic [40:0] HDR_MIN = 41'(STATS_HEADER_BYTES + 10);

    phase_t      phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]  exp_reg, exp_next;
    logic [2:0]  dw_reg, dw_next;
    logic [63:0] asm_reg, asm_next;
    logic [63:0] sum_reg, sum_next;
    logic [31:0] ve_reg, ve_next;

    logic [7:0]  b;
    logic        fend;
    phase_t      eff;
    logic        skip_done, vc_zero, exp_bad, width_bad;
    logic [31:0] vc_m1;
    logic [40:0] need, sl_ext;
    logic [POS_W-1:0] pos_inc;
    logic [63:0] asm_base, asm_delta, delta_val, sum_new;
    logic        base_done, delta_done, emit, emit_last;
    logic [31:0] ve_inc;
    logic        exp_out, width_out, ends_drained;

    assign b         = item.data_byte;
    assign fend      = item.frame_end;
    assign skip_done = (pos_reg >= POS_W'(STATS_HEADER_BYTES));
    assign eff       = (phase_reg == PH_SKIP && skip_done) ? PH_EXP : phase_reg;
    assign vc_zero   = (value_count == 32'd0);
    assign sl_ext    = {7'd0, source_length};
    assign exp_bad   = (sl_ext < HDR_MIN) || (b[7:3] != 5'd0);
    assign vc_m1     = value_count - 32'd1;
    assign need      = HDR_MIN + ((value_count > 32'd1) ?
                       ({9'd0, vc_m1} * {33'd0, b}) : 41'd0);
    assign width_bad = !(b inside {8'd1, 8'd2, 8'd4}) || (sl_ext < need);

    assign pos_inc    = pos_reg + 1'b1;
    assign asm_base   = asm_reg | ({56'd0, b} << {pos_reg[2:0], 3'b000});
    assign asm_delta  = asm_reg | ({56'd0, b} << {pos_reg[1:0], 3'b000});
    assign base_done  = (pos_inc >= POS_W'(8));
    assign delta_done = (pos_inc >= POS_W'(dw_reg));
    assign delta_val  = (asm_delta >> 1) ^ {64{asm_delta[0]}};
    assign sum_new    = (eff == PH_BASE) ? asm_base : sum_reg + delta_val;
    assign emit       = (eff == PH_BASE && base_done) || (eff == PH_DELTA && delta_done);
    assign ve_inc     = ve_reg + 32'd1;
    assign emit_last  = (ve_inc >= value_count);

    assign exp_out      = (eff == PH_EXP) && (vc_zero || exp_bad);
    assign width_out    = (eff == PH_WIDTH) && width_bad;
    assign ends_drained = exp_out || width_out || (emit && emit_last) || (eff == PH_DRAIN);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        exp_next   = exp_reg;
        dw_next    = dw_reg;
        asm_next   = asm_reg;
        sum_next   = sum_reg;
        ve_next    = ve_reg;
        if (accept)
        begin
            case (eff)
                PH_SKIP:
                begin
                    pos_next = pos_inc;
                end
                PH_EXP:
                begin
                    if (exp_out)
                    begin
                        phase_next = PH_DRAIN;
                    end
                    else
                    begin
                        exp_next   = b[2:0];
                        phase_next = PH_WIDTH;
                    end
                end
                PH_WIDTH:
                begin
                    if (width_bad)
                    begin
                        phase_next = PH_DRAIN;
                    end
                    else
                    begin
                        dw_next    = b[2:0];
                        phase_next = PH_BASE;
                        pos_next   = '0;
                        asm_next   = '0;
                    end
                end
                PH_BASE, PH_DELTA:
                begin
                    asm_next = (eff == PH_BASE) ? asm_base : asm_delta;
                    pos_next = pos_inc;
                    if (emit)
                    begin
                        sum_next = sum_new;
                        ve_next  = ve_inc;
                        if (emit_last)
                        begin
                            phase_next = PH_DRAIN;
                        end
                        else
                        begin
                            phase_next = PH_DELTA;
                            pos_next   = '0;
                            asm_next   = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (fend)
            begin
                phase_next = PH_SKIP;
                pos_next   = '0;
                exp_next   = '0;
                dw_next    = '0;
                asm_next   = '0;
                sum_next   = '0;
                ve_next    = '0;
            end
        end
    end

    // outputs
    always_comb
    begin
        job.is_value = 1'b0;
        job.status   = ST_ERROR;
        job.last     = 1'b1;
        job.ex       = exp_reg;
        job.sum      = '0;
        job_push     = 1'b0;
        if (exp_out)
        begin
            job.status = vc_zero ? ST_EMPTY : ST_ERROR;
            job_push   = 1'b1;
        end
        else if (width_out)
        begin
            job_push = 1'b1;
        end
        else if (emit)
        begin
            job.is_value = 1'b1;
            job.status   = ST_VALUE;
            job.last     = emit_last;
            job.sum      = sum_new;
            job_push     = 1'b1;
        end
        if (fend && !ends_drained)
        begin
            job.is_value = 1'b0;
            job.status   = vc_zero ? ST_EMPTY : ST_ERROR;
            job.last     = 1'b1;
            job.sum      = '0;
            job_push     = 1'b1;
        end
        job_push = job_push && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            pos_reg   <= '0;
            exp_reg   <= '0;
            dw_reg    <= '0;
            asm_reg   <= '0;
            sum_reg   <= '0;
            ve_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            exp_reg   <= exp_next;
            dw_reg    <= dw_next;
            asm_reg   <= asm_next;
            sum_reg   <= sum_next;
            ve_reg    <= ve_next;
        end
    end

endmodule

// File: src/dds_convert.sv
// -----------------------------------------------------------------------------
// dds_convert
// Back end: eight-stage pipeline that turns a 64-bit sum into a double and
// scales it by 1 / 10^e, both rounded to nearest even.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dds_convert import dds_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  job_t    job,
    input  logic    job_valid,
    output logic    job_pop,
    output result_t res,
    output logic    res_valid,
    input  logic    res_full
);

    logic [7:0]  v_reg;
    meta_t       meta_reg [7];
    logic        en;

    logic [63:0]      mag0_reg, mag1_reg, mag2_reg, norm3_reg;
    logic [7:0][3:0]  grp1_reg;
    logic [6:0]       lzc2_reg;
    logic [5:0]       e3_reg;
    logic             zero3_reg, zero4_reg, zero5_reg, zero6_reg;
    logic [52:0]      m4_reg;
    logic [6:0]       e4_reg;
    logic [51:0]      hh5_reg;
    logic [52:0]      hl5_reg, lh5_reg;
    logic [53:0]      ll5_reg;
    logic [11:0]      esum5_reg, esum6_reg;
    logic [105:0]     prod6_reg;
    result_t          res7_reg, res7_next;

    logic [63:0]      mag0_next;
    logic [7:0][3:0]  grp1_next;
    logic [6:0]       lzc2_next;
    logic [53:0]      r4;
    logic [63:0]      recip;
    logic [52:0]      m2;
    logic [105:0]     prod6_next;

    assign en        = !(v_reg[7] && res_full);
    assign job_pop   = en && job_valid;
    assign res_valid = v_reg[7];
    assign res       = res7_reg;

    assign mag0_next = job.sum[63] ? (~job.sum + 64'd1) : job.sum;

    always_comb
    begin
        for (int g = 0; g < 8; g++)
        begin
            grp1_next[g] = lzc8(mag0_reg[63 - 8 * g -: 8]);
        end
    end

    always_comb
    begin
        logic hit;
        hit       = 1'b0;
        lzc2_next = 7'd64;
        for (int g = 0; g < 8; g++)
        begin
            if (!hit && grp1_reg[g] != 4'd8)
            begin
                hit       = 1'b1;
                lzc2_next = 7'(8 * g) + {3'd0, grp1_reg[g]};
            end
        end
    end

    assign r4 = {1'b0, norm3_reg[63:11]} +
                54'(norm3_reg[10] & ((|norm3_reg[9:0]) | norm3_reg[11]));

    assign recip = recip_bits(meta_reg[4].ex);
    assign m2    = {1'b1, recip[51:0]};

    assign prod6_next = ({54'd0, hh5_reg} << 54) +
                        ({52'd0, ({1'b0, hl5_reg} + {1'b0, lh5_reg})} << 27) +
                        {52'd0, ll5_reg};

    always_comb
    begin
        logic        hi, g, st, inc, carry;
        logic [52:0] mant;
        logic [53:0] r;
        logic [11:0] e;
        hi    = prod6_reg[105];
        mant  = hi ? prod6_reg[105:53] : prod6_reg[104:52];
        g     = hi ? prod6_reg[52] : prod6_reg[51];
        st    = hi ? (|prod6_reg[51:0]) : (|prod6_reg[50:0]);
        inc   = g & (st | mant[0]);
        r     = {1'b0, mant} + 54'(inc);
        carry = r[53];
        e     = esum6_reg + 12'(hi) + 12'(carry);
        res7_next.status      = meta_reg[6].status;
        res7_next.last_result = meta_reg[6].last;
        if (!meta_reg[6].is_value || zero6_reg)
        begin
            res7_next.value_bits = '0;
        end
        else
        begin
            res7_next.value_bits = {meta_reg[6].sign, e[10:0], carry ? 52'd0 : r[51:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[6:0], job_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0].is_value <= job.is_value;
            meta_reg[0].status   <= job.status;
            meta_reg[0].last     <= job.last;
            meta_reg[0].sign     <= job.sum[63];
            meta_reg[0].ex       <= job.ex;
            for (int k = 1; k < 7; k++)
            begin
                meta_reg[k] <= meta_reg[k - 1];
            end
            mag0_reg  <= mag0_next;
            mag1_reg  <= mag0_reg;
            grp1_reg  <= grp1_next;
            mag2_reg  <= mag1_reg;
            lzc2_reg  <= lzc2_next;
            norm3_reg <= mag2_reg << lzc2_reg[5:0];
            e3_reg    <= 6'd63 - lzc2_reg[5:0];
            zero3_reg <= lzc2_reg[6];
            m4_reg    <= r4[53] ? {1'b1, 52'd0} : r4[52:0];
            e4_reg    <= {1'b0, e3_reg} + 7'(r4[53]);
            zero4_reg <= zero3_reg;
            hh5_reg   <= m4_reg[52:27] * m2[52:27];
            hl5_reg   <= m4_reg[52:27] * m2[26:0];
            lh5_reg   <= m4_reg[26:0] * m2[52:27];
            ll5_reg   <= m4_reg[26:0] * m2[26:0];
            esum5_reg <= {1'b0, recip[62:52]} + {5'd0, e4_reg};
            zero5_reg <= zero4_reg;
            prod6_reg <= prod6_next;
            esum6_reg <= esum5_reg;
            zero6_reg <= zero5_reg;
            res7_reg  <= res7_next;
        end
    end

endmodule

// File: src/decimal_delta_stream_decoder.sv
// One encoded frame byte is taken per clock cycle as long as full is low; full
// rises only when results back up and the four-word job queue behind the
// parser fills. Each result leaves the eight-stage convert-and-scale pipeline
// and then waits in a two-word result queue.
// Registers: value_count at address 0x0, source_length at 0x8 (64-bit data).
// -----------------------------------------------------------------------------
// decimal_delta_stream_decoder
// Frame parser, job queue, conversion pipeline and result queue.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_delta_stream_decoder import dds_pkg::*; #(
    parameter int STATS_HEADER_BYTES = STATS_HEADER_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  item_t             item,
    output logic              full,
    input  logic              pop,
    output result_t           result,
    output logic              empty,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    logic [31:0] vc_reg;
    logic [33:0] sl_reg;
    logic        accept, job_push, job_pop, job_empty, res_valid, res_full;
    job_t        job_w, job_r;
    result_t     res_w;

    assign pready = 1'b1;
    assign accept = push && !full;

    always_comb
    begin
        case (paddr[3])
            REG_VALUE_COUNT:   prdata = {32'd0, vc_reg};
            REG_SOURCE_LENGTH: prdata = {30'd0, sl_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= '0;
            sl_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3])
                REG_VALUE_COUNT:   vc_reg <= pwdata[31:0];
                REG_SOURCE_LENGTH: sl_reg <= pwdata[33:0];
                default:
                begin
                end
            endcase
        end
    end

    dds_parser #(
        .STATS_HEADER_BYTES(STATS_HEADER_BYTES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .accept        (accept),
        .value_count   (vc_reg),
        .source_length (sl_reg),
        .job           (job_w),
        .job_push      (job_push)
    );

    dds_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_QUEUE_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_w),
        .full  (full),
        .pop   (job_pop),
        .rdata (job_r),
        .empty (job_empty)
    );

    dds_convert u_convert (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_r),
        .job_valid (!job_empty),
        .job_pop   (job_pop),
        .res       (res_w),
        .res_valid (res_valid),
        .res_full  (res_full)
    );

    dds_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .wdata (res_w),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

// File: src/dds_checker.sv
// -----------------------------------------------------------------------------
// dds_checker
// Port-level checks on the result word stream of the decoder.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dds_checker import dds_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    pop,
    input logic    empty,
    input result_t result
);

    `DDS_ASSERT_ALWAYS(a_bits_zero, empty || result.status == ST_VALUE || result.value_bits == 64'd0, "value_bits set on a non-value word")
    `DDS_ASSERT_ALWAYS(a_status_last, empty || result.status == ST_VALUE || result.last_result, "empty or error word not marked last")
    `DDS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result), "waiting result word changed")

endmodule

bind decimal_delta_stream_decoder dds_checker u_chk (.*);

// File: tb/decimal_delta_stream_decoder_tb.sv
// -----------------------------------------------------------------------------
// decimal_delta_stream_decoder_tb
// Sends encoded frames byte by byte into the decoder, predicts every result
// word with a behavioral copy of the frame parser and its scaled conversion,
// and checks each popped word in order under varied sender and receiver idling.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_delta_stream_decoder_tb;
    import dds_pkg::*;

    localparam int HDR = STATS_HEADER_BYTES_DEF;
    localparam logic [ADDR_W-1:0] ADDR_COUNT  = ADDR_W'(8 * REG_VALUE_COUNT);
    localparam logic [ADDR_W-1:0] ADDR_LENGTH = ADDR_W'(8 * REG_SOURCE_LENGTH);

    logic              clk;
    logic              rst_n;
    logic              push;
    item_t             item;
    logic              full;
    logic              pop;
    result_t           result;
    logic              empty;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;

    decimal_delta_stream_decoder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .pop     (pop),
        .result  (result),
        .empty   (empty),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // decoder model state
    logic [31:0] cfg_count;
    logic [33:0] cfg_length;
    logic [33:0] byte_pos;
    phase_t      phase;
    logic [2:0]  exponent;
    logic [2:0]  delta_width;
    logic [63:0] assembly;
    logic [63:0] running_sum;
    logic [31:0] emitted;

    result_t pending_results[$];
    int      errors;
    int      sent_bytes;
    int      send_idle_pct;
    int      pop_stall_pct;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    always @(negedge clk)
    begin
        pop = ($urandom_range(99) >= pop_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected word: value_bits %h status %0d", result.value_bits,
                       result.status);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.value_bits !== want.value_bits)
                begin
                    $error("value_bits: expected %h actual %h", want.value_bits,
                           result.value_bits);
                    errors++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d actual %0d", want.status, result.status);
                    errors++;
                end
                if (result.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0d actual %0d", want.last_result,
                           result.last_result);
                    errors++;
                end
            end
        end
    end

    function automatic logic [63:0] scale_to_double(logic [63:0] acc, logic [2:0] ex);
        real p;
        real v;
        p = 1.0;
        for (int i = 0; i < ex; i++)
        begin
            p = p * 10.0;
        end
        v = real'($signed(acc));
        return $realtobits(v * (1.0 / p));
    endfunction

    task automatic clear_frame_state();
        byte_pos    = '0;
        phase       = PH_SKIP;
        exponent    = '0;
        delta_width = '0;
        assembly    = '0;
        running_sum = '0;
        emitted     = '0;
    endtask

    task automatic emit_value(output result_t r);
        emitted++;
        r = '{scale_to_double(running_sum, exponent), ST_VALUE, emitted >= cfg_count};
        if (r.last_result)
        begin
            phase = PH_DRAIN;
        end
        else
        begin
            phase    = PH_DELTA;
            byte_pos = '0;
            assembly = '0;
        end
    endtask

    task automatic decode_byte(input item_t it);
        result_t     r;
        bit          hit;
        logic [63:0] need;
        logic [7:0]  b;
        hit = 0;
        b   = it.data_byte;
        r   = '0;
        if (phase == PH_SKIP)
        begin
            if (byte_pos < HDR)
            begin
                byte_pos++;
            end
            else
            begin
                phase = PH_EXP;
            end
        end
        if (phase == PH_EXP)
        begin
            if (cfg_count == 0)
            begin
                r     = '{64'd0, ST_EMPTY, 1'b1};
                hit   = 1;
                phase = PH_DRAIN;
            end
            else if (cfg_length < HDR + 10 || b > 7)
            begin
                r     = '{64'd0, ST_ERROR, 1'b1};
                hit   = 1;
                phase = PH_DRAIN;
            end
            else
            begin
                exponent = b[2:0];
                phase    = PH_WIDTH;
            end
        end
        else if (phase == PH_WIDTH)
        begin
            need = HDR + 10;
            if (cfg_count > 1)
            begin
                need += 64'(cfg_count - 1) * b;
            end
            if ((b != 1 && b != 2 && b != 4) || 64'(cfg_length) < need)
            begin
                r     = '{64'd0, ST_ERROR, 1'b1};
                hit   = 1;
                phase = PH_DRAIN;
            end
            else
            begin
                delta_width = b[2:0];
                phase       = PH_BASE;
                byte_pos    = '0;
                assembly    = '0;
            end
        end
        else if (phase == PH_BASE)
        begin
            assembly |= 64'(b) << (byte_pos[2:0] * 8);
            byte_pos++;
            if (byte_pos >= 8)
            begin
                running_sum = assembly;
                emit_value(r);
                hit = 1;
            end
        end
        else if (phase == PH_DELTA)
        begin
            assembly |= 64'(b) << (byte_pos[1:0] * 8);
            byte_pos++;
            if (byte_pos >= delta_width)
            begin
                running_sum += (assembly >> 1) ^ (64'd0 - {63'd0, assembly[0]});
                emit_value(r);
                hit = 1;
            end
        end
        if (it.frame_end)
        begin
            if (phase != PH_DRAIN)
            begin
                r   = '{64'd0, (cfg_count == 0) ? ST_EMPTY : ST_ERROR, 1'b1};
                hit = 1;
            end
            clear_frame_state();
        end
        if (hit)
        begin
            pending_results.push_back(r);
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic fend);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        item = '{b, fend};
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        decode_byte(item);
        sent_bytes++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        push = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [63:0] data);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input logic [31:0] count, input logic [33:0] length);
        wait_idle();
        write_reg(ADDR_COUNT, 64'(count));
        write_reg(ADDR_LENGTH, 64'(length));
        cfg_count  = count;
        cfg_length = length;
    endtask

    // full frame: header, exponent, width, base, deltas, surplus; cut > 0 truncates
    task automatic send_frame(input logic [7:0] exb, input logic [7:0] wb,
                              input logic [63:0] base, input int ndeltas,
                              input int surplus, input int cut);
        logic [7:0] frame[$];
        int         w;
        w = (wb == 1 || wb == 2 || wb == 4) ? wb : 1;
        for (int i = 0; i < HDR; i++)
        begin
            frame.push_back(8'($urandom));
        end
        frame.push_back(exb);
        frame.push_back(wb);
        for (int i = 0; i < 8; i++)
        begin
            frame.push_back(base[8*i +: 8]);
        end
        for (int i = 0; i < ndeltas * w + surplus; i++)
        begin
            frame.push_back(8'($urandom));
        end
        if (cut > 0 && cut < frame.size())
        begin
            frame = frame[0:cut-1];
        end
        foreach (frame[i])
        begin
            send_word(frame[i], i == frame.size() - 1);
        end
    endtask

    task automatic test_empty_and_errors();
        set_config(32'd0, 34'd100);
        send_frame(8'd3, 8'd1, 64'd5, 2, 1, 0);
        set_config(32'd3, 34'd57);
        send_frame(8'd0, 8'd1, 64'd5, 2, 0, 0);
        set_config(32'd3, 34'h3_FFFF_FFFF);
        send_frame(8'd8, 8'd1, 64'd5, 2, 0, 0);
        send_frame(8'd255, 8'd1, 64'd5, 2, 0, 0);
        send_frame(8'd2, 8'd3, 64'd5, 2, 0, 0);
        send_frame(8'd2, 8'd0, 64'd5, 2, 0, 0);
        send_frame(8'd2, 8'd255, 64'd5, 2, 0, 0);
        set_config(32'd3, 34'd61);
        send_frame(8'd2, 8'd2, 64'd5, 2, 0, 0);
        set_config(32'hFFFF_FFFF, 34'h3_FFFF_FFFF);
        send_frame(8'd1, 8'd4, 64'd5, 2, 0, 0);
        send_frame(8'd1, 8'd1, 64'd5, 2, 0, 0);
    endtask

    task automatic test_value_extremes();
        set_config(32'd1, 34'd58);
        send_frame(8'd0, 8'd4, 64'h8000_0000_0000_0000, 0, 3, 0);
        send_frame(8'd7, 8'd1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
        send_frame(8'd7, 8'd2, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0);
        send_frame(8'd3, 8'd1, 64'd0, 0, 0, 0);
        set_config(32'd4, 34'd70);
        send_frame(8'd0, 8'd1, 64'h7FFF_FFFF_FFFF_FFFF, 3, 0, 0);
        send_frame(8'd5, 8'd2, 64'h8000_0000_0000_0001, 3, 2, 0);
        send_frame(8'd6, 8'd4, {$urandom, $urandom}, 3, 0, 0);
    endtask

    task automatic test_early_end();
        set_config(32'd4, 34'd70);
        send_frame(8'd2, 8'd2, 64'd9, 3, 0, 20);
        send_frame(8'd2, 8'd2, 64'd9, 3, 0, 49);
        send_frame(8'd2, 8'd2, 64'd9, 3, 0, 50);
        send_frame(8'd2, 8'd2, 64'd9, 3, 0, 55);
        send_frame(8'd2, 8'd2, 64'd9, 3, 0, 62);
        set_config(32'd0, 34'd70);
        send_frame(8'd2, 8'd2, 64'd9, 3, 0, 30);
    endtask

    task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                      input int budget);
        int          stop_at;
        int          cnt;
        int          w;
        int          kind;
        logic [7:0]  wb;
        logic [63:0] base;
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        stop_at       = sent_bytes + budget;
        while (sent_bytes < stop_at)
        begin
            cnt  = $urandom_range(1, 8);
            w    = 1 << $urandom_range(2);
            wb   = 8'(w);
            kind = $urandom_range(99);
            base = {$urandom, $urandom};
            if ($urandom_range(3) == 0)
            begin
                base = {{32{base[40]}}, base[31:0]};
            end
            if (kind < 4)
            begin
                set_config(32'd0, 34'($urandom_range(200)));
            end
            else if (kind < 10)
            begin
                set_config(32'(cnt), 34'(HDR + 10 + (cnt - 1) * w - $urandom_range(1, 3)));
            end
            else
            begin
                set_config(32'(cnt), 34'(HDR + 10 + (cnt - 1) * 4 + $urandom_range(40)));
            end
            if (kind < 75)
            begin
                send_frame(8'($urandom_range(7)), wb, base, cnt - 1, $urandom_range(3), 0);
            end
            else if (kind < 85)
            begin
                send_frame(8'($urandom_range(7)), wb, base, cnt - 1, 0,
                           $urandom_range(1, 58 + (cnt - 1) * w));
            end
            else if (kind < 92)
            begin
                send_frame(8'($urandom_range(255)), 8'($urandom_range(6)), base, cnt - 1,
                           0, 0);
            end
            else
            begin
                repeat ($urandom_range(5, 80))
                begin
                    send_word(8'($urandom), $urandom_range(19) == 0);
                end
                send_word(8'($urandom), 1'b1);
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        item          = '0;
        pop           = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        errors        = 0;
        sent_bytes    = 0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        cfg_count     = '0;
        cfg_length    = '0;
        clear_frame_state();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_and_errors();
        test_value_extremes();
        test_early_end();
        test_random_frames(0, 0, 40);
        test_random_frames(50, 0, 40);
        test_random_frames(0, 50, 40);
        test_random_frames(33, 33, 40);

        wait_idle();
        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
